### rtl/fbor_pkg.sv
// ----------------------------------------------------------------------------
// fbor_pkg
// Shared types, codes and helpers of the field byte-order repacker.
// ----------------------------------------------------------------------------
package fbor_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int CFG_DATA_W          = 16;
    localparam int CFG_INDEX_W         = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LAYOUT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LAYOUT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_CAPACITY = 2'd2;

    // layout codes
    localparam logic [1:0] LAYOUT_BIG_2    = 2'd0;
    localparam logic [1:0] LAYOUT_LITTLE_2 = 2'd1;
    localparam logic [1:0] LAYOUT_LITTLE_4 = 2'd2;
    localparam logic [1:0] LAYOUT_BIG_4    = 2'd3;

    // input kind tags
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_HALF = 2'd1;
    localparam logic [1:0] KIND_WORD = 2'd2;

    // latched field kind
    localparam logic [1:0] FIELD_NONE = 2'd0;
    localparam logic [1:0] FIELD_BYTE = 2'd1;
    localparam logic [1:0] FIELD_HALF = 2'd2;
    localparam logic [1:0] FIELD_WORD = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_OVER       = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // one emit request handed from front to back
    typedef struct packed {
        logic        is_status;   // status-only request, no bytes
        logic        over;        // field reaches past capacity
        logic [1:0]  pad_count;   // target pad bytes before the field
        logic [2:0]  data_count;  // field bytes, 1, 2 or 4
        logic [31:0] data;        // field bytes in output order, first at [7:0]
    } fbor_job_t;

    function automatic logic is_big(input logic [1:0] layout);
        is_big = (layout == LAYOUT_BIG_2) || (layout == LAYOUT_BIG_4);
    endfunction

    function automatic logic [1:0] kind_to_field(input logic [1:0] kind);
        case (kind)
            KIND_HALF: kind_to_field = FIELD_HALF;
            KIND_WORD: kind_to_field = FIELD_WORD;
            default:   kind_to_field = FIELD_BYTE;
        endcase
    endfunction

    function automatic logic [2:0] field_size(input logic [1:0] field);
        case (field)
            FIELD_WORD: field_size = 3'd4;
            FIELD_HALF: field_size = 3'd2;
            default:    field_size = 3'd1;
        endcase
    endfunction

    function automatic logic [1:0] align_pad(input logic [1:0] layout,
                                             input logic [1:0] field,
                                             input logic [1:0] off);
        case (field)
            FIELD_HALF: align_pad = {1'b0, off[0]};
            FIELD_WORD:
            begin
                if (layout == LAYOUT_LITTLE_4 || layout == LAYOUT_BIG_4)
                    align_pad = 2'd0 - off;
                else
                    align_pad = {1'b0, off[0]};
            end
            default:    align_pad = 2'd0;
        endcase
    endfunction

endpackage

### rtl/fbor_front.sv
// ----------------------------------------------------------------------------
// fbor_front
// Takes one source byte per cycle unless queue_full, drops source pads,
// gathers fields; issues a request per full field or unfinished buffer end.
// ----------------------------------------------------------------------------
module fbor_front #(
    parameter int OFFSET_BITS = fbor_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic [1:0]             kind,
    input  logic                   first_of_buffer,
    input  logic                   end_of_buffer,
    input  logic [1:0]             source_layout,
    input  logic [1:0]             target_layout,
    input  logic [15:0]            output_capacity,
    input  logic                   queue_full,
    output logic                   push,
    output fbor_pkg::fbor_job_t    job,
    output logic [OFFSET_BITS-1:0] job_position
);

    localparam int END_W = OFFSET_BITS + 1;
    localparam int CMP_W = (END_W > 16) ? END_W : 16;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] source_offset_reg, source_offset_next;
    logic [OFFSET_BITS-1:0] target_offset_reg, target_offset_next;
    logic [1:0]             field_reg, field_next;
    logic [2:0]             count_reg, count_next;
    logic [1:0]             skip_reg, skip_next;
    logic [31:0]            gathered_reg, gathered_next;

    logic                   accept;
    logic [OFFSET_BITS-1:0] so_base, to_base;
    logic [1:0]             field_base, field_cur, skip_cur, tpad;
    logic [2:0]             count_cur, count_inc, size;
    logic                   open_now, done, still_open, status_req;
    logic [END_W-1:0]       end_pos;
    logic [31:0]            gathered_ins;

    function automatic logic [31:0] reorder(input logic [31:0] gb,
                                            input logic [2:0]  sz,
                                            input logic        same);
        logic [31:0] r;
        r = gb;
        if (!same)
        begin
            if (sz == 3'd4)
                r = {gb[7:0], gb[15:8], gb[23:16], gb[31:24]};
            else if (sz == 3'd2)
                r = {gb[31:16], gb[7:0], gb[15:8]};
        end
        reorder = r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        so_base    = first_of_buffer ? '0 : source_offset_reg;
        to_base    = first_of_buffer ? '0 : target_offset_reg;
        field_base = first_of_buffer ? fbor_pkg::FIELD_NONE : field_reg;
        open_now   = (field_base == fbor_pkg::FIELD_NONE);
        field_cur  = open_now ? fbor_pkg::kind_to_field(kind) : field_base;
        count_cur  = (open_now || first_of_buffer) ? 3'd0 : count_reg;
        skip_cur   = open_now ? fbor_pkg::align_pad(source_layout, field_cur, so_base[1:0])
                              : (first_of_buffer ? 2'd0 : skip_reg);
        size       = fbor_pkg::field_size(field_cur);
        count_inc  = count_cur + 3'd1;

        gathered_ins = gathered_reg;
        gathered_ins[8*count_cur[1:0] +: 8] = in_byte;

        tpad    = fbor_pkg::align_pad(target_layout, field_cur, to_base[1:0]);
        end_pos = END_W'(to_base) + END_W'(tpad) + END_W'(size);

        done               = 1'b0;
        field_next         = field_cur;
        count_next         = count_cur;
        skip_next          = skip_cur;
        gathered_next      = gathered_reg;
        target_offset_next = to_base;

        if (skip_cur != 2'd0)
            skip_next = skip_cur - 2'd1;
        else
        begin
            gathered_next = gathered_ins;
            count_next    = count_inc;
            if (count_inc >= size)
            begin
                done               = 1'b1;
                field_next         = fbor_pkg::FIELD_NONE;
                count_next         = 3'd0;
                target_offset_next = end_pos[OFFSET_BITS] ? POS_MAX
                                                          : end_pos[OFFSET_BITS-1:0];
            end
        end

        still_open = !done;
        status_req = end_of_buffer && still_open;
        if (status_req)
        begin
            field_next = fbor_pkg::FIELD_NONE;
            count_next = 3'd0;
            skip_next  = 2'd0;
        end

        source_offset_next = (so_base == POS_MAX) ? POS_MAX : so_base + 1'b1;

        job.is_status  = !done;
        job.over       = CMP_W'(end_pos) > CMP_W'(output_capacity);
        job.pad_count  = tpad;
        job.data_count = size;
        job.data       = reorder(gathered_ins, size,
                                 fbor_pkg::is_big(source_layout)
                                 == fbor_pkg::is_big(target_layout));
        job_position   = to_base;
        push           = accept && (done || status_req);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_offset_reg <= '0;
            target_offset_reg <= '0;
            field_reg         <= fbor_pkg::FIELD_NONE;
            count_reg         <= 3'd0;
            skip_reg          <= 2'd0;
        end
        else if (accept)
        begin
            source_offset_reg <= source_offset_next;
            target_offset_reg <= target_offset_next;
            field_reg         <= field_next;
            count_reg         <= count_next;
            skip_reg          <= skip_next;
        end
    end

    // gathered bytes are only read where written for the open field
    always_ff @(posedge clk)
    begin
        if (accept)
            gathered_reg <= gathered_next;
    end

endmodule

### rtl/fbor_queue.sv
// ----------------------------------------------------------------------------
// fbor_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module fbor_queue #(
    parameter int OFFSET_BITS = fbor_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fbor_pkg::fbor_job_t    push_job,
    input  logic [OFFSET_BITS-1:0] push_position,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output fbor_pkg::fbor_job_t    head_job,
    output logic [OFFSET_BITS-1:0] head_position
);

    localparam int CNT_W = fbor_pkg::QUEUE_PTR_W + 1;

    fbor_pkg::fbor_job_t    job_mem [fbor_pkg::QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] pos_mem [fbor_pkg::QUEUE_DEPTH];

    logic [fbor_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]                 count_reg;

    assign full          = (count_reg == CNT_W'(fbor_pkg::QUEUE_DEPTH));
    assign not_empty     = (count_reg != '0);
    assign head_job      = job_mem[rd_ptr_reg];
    assign head_position = pos_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[wr_ptr_reg] <= push_job;
            pos_mem[wr_ptr_reg] <= push_position;
        end
    end

endmodule

### rtl/fbor_back.sv
// ----------------------------------------------------------------------------
// fbor_back
// Walks the head request one result per cycle while out_ready is high: target
// pad bytes, then the field bytes, or a single status-only result.
// ----------------------------------------------------------------------------
module fbor_back #(
    parameter int OFFSET_BITS = fbor_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  fbor_pkg::fbor_job_t    head_job,
    input  logic [OFFSET_BITS-1:0] head_position,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic [OFFSET_BITS-1:0] out_position,
    output logic                   is_padding,
    output logic                   byte_valid,
    output logic [1:0]             status,
    output logic                   last_of_run
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [2:0]             step_reg;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [2:0]             total;
    logic [1:0]             data_idx;
    logic                   in_pad, take;

    always_comb
    begin
        total    = {1'b0, head_job.pad_count} + head_job.data_count;
        in_pad   = step_reg < {1'b0, head_job.pad_count};
        data_idx = step_reg[1:0] - head_job.pad_count;

        out_valid    = head_valid;
        out_position = (step_reg == 3'd0) ? head_position : pos_reg;
        if (head_job.is_status)
        begin
            out_byte    = 8'd0;
            is_padding  = 1'b0;
            byte_valid  = 1'b0;
            status      = fbor_pkg::STATUS_INCOMPLETE;
            last_of_run = 1'b1;
        end
        else
        begin
            out_byte    = in_pad ? 8'd0 : head_job.data[8*data_idx +: 8];
            is_padding  = in_pad;
            byte_valid  = 1'b1;
            status      = head_job.over ? fbor_pkg::STATUS_OVER : fbor_pkg::STATUS_OK;
            last_of_run = (step_reg == total - 3'd1);
        end
        take = out_valid && out_ready;
        pop  = take && last_of_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            pos_reg  <= '0;
        end
        else if (take)
        begin
            step_reg <= last_of_run ? 3'd0 : step_reg + 3'd1;
            pos_reg  <= (out_position == POS_MAX) ? POS_MAX : out_position + 1'b1;
        end
    end

endmodule

### rtl/field_byte_order_repacker.sv
// ----------------------------------------------------------------------------
// field_byte_order_repacker
// Regathers tagged source fields and re-emits them in the target byte order.
// ----------------------------------------------------------------------------
// The front end takes one source byte per cycle while the two-entry request
// queue has room; the back end sends one result per cycle while out_ready is
// high, so a completed field yields its target pad count plus its size in
// results (1 to 7), an unfinished buffer end yields one, and skipped source
// pads yield none. The back end's single output port sets the sustained rate.
// Configuration takes effect on the next source byte and must be written
// while the block is idle.
module field_byte_order_repacker #(
    parameter int OFFSET_BITS = fbor_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fbor_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbor_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic [1:0]                       kind,
    input  logic                             first_of_buffer,
    input  logic                             end_of_buffer,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic [OFFSET_BITS-1:0]           out_position,
    output logic                             is_padding,
    output logic                             byte_valid,
    output logic [1:0]                       status,
    output logic                             last_of_run
);

    logic [1:0]  source_layout_reg;
    logic [1:0]  target_layout_reg;
    logic [15:0] output_capacity_reg;

    logic                   push, pop, queue_full, queue_not_empty;
    fbor_pkg::fbor_job_t    push_job, head_job;
    logic [OFFSET_BITS-1:0] push_position, head_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_layout_reg   <= fbor_pkg::LAYOUT_BIG_2;
            target_layout_reg   <= fbor_pkg::LAYOUT_BIG_2;
            output_capacity_reg <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fbor_pkg::REG_SOURCE_LAYOUT:   source_layout_reg   <= cfg_data[1:0];
                fbor_pkg::REG_TARGET_LAYOUT:   target_layout_reg   <= cfg_data[1:0];
                fbor_pkg::REG_OUTPUT_CAPACITY: output_capacity_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    fbor_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .kind            (kind),
        .first_of_buffer (first_of_buffer),
        .end_of_buffer   (end_of_buffer),
        .source_layout   (source_layout_reg),
        .target_layout   (target_layout_reg),
        .output_capacity (output_capacity_reg),
        .queue_full      (queue_full),
        .push            (push),
        .job             (push_job),
        .job_position    (push_position)
    );

    fbor_queue #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_job      (push_job),
        .push_position (push_position),
        .pop           (pop),
        .full          (queue_full),
        .not_empty     (queue_not_empty),
        .head_job      (head_job),
        .head_position (head_position)
    );

    fbor_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (queue_not_empty),
        .head_job      (head_job),
        .head_position (head_position),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_position  (out_position),
        .is_padding    (is_padding),
        .byte_valid    (byte_valid),
        .status        (status),
        .last_of_run   (last_of_run)
    );

endmodule
